@@ sv/cobs_pkg.sv @@
// Shared types and constants for the byte-stuffed stream decoder.
// No dependencies; every other file of the decoder depends on this package.
package cobs_pkg;

   localparam int unsigned BYTE_W = 8;

   localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd0;
   localparam logic [BYTE_W-1:0] DEPTH_RESET = 8'd255;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [1:0] {
      ACT_FEED    = 2'd0,
      ACT_RESTART = 2'd1,
      ACT_RESYNC  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_END   = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_DELIMITER = 1'b0,
      CSR_DEPTH     = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      MODE_CODE = 4'b0001,
      MODE_DATA = 4'b0010,
      MODE_SWAP = 4'b0100,
      MODE_WAIT = 4'b1000
   } mode_type;

   typedef struct packed {
      byte_type delimiter_value;
      byte_type block_depth;
   } cfg_type;

   typedef struct packed {
      byte_type   out_byte;
      status_type status;
      logic       last_of_run;
   } result_type;

   // Results produced by one request: count (0..2) and the two slots in order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

endpackage

@@ sv/cobs_req_if.sv @@
// Request channel of the decoder: valid/ready handshake, action and byte.
// Depends on cobs_pkg for the payload types.
interface cobs_req_if;
   logic                 valid;
   logic                 ready;
   cobs_pkg::action_type action;
   cobs_pkg::byte_type   in_byte;

   modport source (output valid, action, in_byte, input ready);
   modport sink   (input valid, action, in_byte, output ready);
endinterface

@@ sv/cobs_rsp_if.sv @@
// Result channel of the decoder: valid/ready handshake and one result.
// Depends on cobs_pkg for the payload types.
interface cobs_rsp_if;
   logic                 valid;
   logic                 ready;
   cobs_pkg::byte_type   out_byte;
   cobs_pkg::status_type status;
   logic                 last_of_run;

   modport source (output valid, out_byte, status, last_of_run, input ready);
   modport sink   (input valid, out_byte, status, last_of_run, output ready);
endinterface

@@ sv/cobs_csr_if.sv @@
// Configuration write channel: valid/ready handshake, register index, data.
// Depends on cobs_pkg for the index and data types.
interface cobs_csr_if;
   logic                  valid;
   logic                  ready;
   cobs_pkg::csr_idx_type index;
   cobs_pkg::byte_type    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/cobs_step.sv @@
// Decode state and the per-request next-state / result logic.
// Depends on cobs_pkg.
module cobs_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  cobs_pkg::action_type action,
   input  cobs_pkg::byte_type   in_byte,
   input  cobs_pkg::cfg_type    cfg,
   output cobs_pkg::step_type   step
);
   import cobs_pkg::*;

   mode_type mode_ff, mode_in;
   byte_type swap_ff, swap_in;
   byte_type block_ff, block_in;

   logic     is_delim;
   byte_type code_val;
   logic     code_bad;
   logic     advance;
   byte_type blk_dec;
   byte_type swp_dec;

   assign is_delim = (in_byte == cfg.delimiter_value);
   assign code_val = (in_byte == '0 && cfg.delimiter_value != '0) ? cfg.delimiter_value
                                                                 : in_byte;
   assign code_bad = (code_val > cfg.block_depth);

   always_comb begin
      mode_in  = mode_ff;
      swap_in  = swap_ff;
      block_in = block_ff;
      advance  = 1'b0;
      blk_dec  = '0;
      swp_dec  = '0;
      step     = '0;

      unique case (action)
         ACT_RESTART: begin
            mode_in  = MODE_CODE;
            swap_in  = '0;
            block_in = cfg.block_depth;
         end
         ACT_RESYNC: begin
            mode_in  = MODE_WAIT;
            swap_in  = '0;
            block_in = cfg.block_depth;
         end
         ACT_FEED: begin
            unique case (mode_ff)
               MODE_CODE: begin
                  if (is_delim) begin
                     swap_in  = '0;
                     block_in = cfg.block_depth;
                  end else begin
                     swap_in  = code_val;
                     block_in = cfg.block_depth;
                     if (code_bad) begin
                        step.count = 2'd1;
                        step.first = '{out_byte: in_byte, status: ST_ERROR, last_of_run: 1'b1};
                        mode_in    = MODE_WAIT;
                     end else begin
                        advance = 1'b1;
                     end
                  end
               end
               MODE_DATA: begin
                  step.count = 2'd1;
                  if (is_delim) begin
                     step.first = '{out_byte: in_byte, status: ST_ERROR, last_of_run: 1'b1};
                     mode_in    = MODE_CODE;
                  end else begin
                     step.first = '{out_byte: in_byte, status: ST_OK, last_of_run: 1'b1};
                     advance    = 1'b1;
                  end
               end
               MODE_SWAP: begin
                  if (is_delim) begin
                     // frame end: restart expecting a code byte
                     step.count = 2'd1;
                     step.first = '{out_byte: in_byte, status: ST_END, last_of_run: 1'b1};
                     mode_in    = MODE_CODE;
                     swap_in    = '0;
                     block_in   = cfg.block_depth;
                  end else begin
                     swap_in  = code_val;
                     block_in = cfg.block_depth;
                     if (code_bad) begin
                        // error first, then the implied delimiter still goes out
                        step.count  = 2'd2;
                        step.first  = '{out_byte: in_byte, status: ST_ERROR,
                                        last_of_run: 1'b0};
                        step.second = '{out_byte: cfg.delimiter_value, status: ST_OK,
                                        last_of_run: 1'b1};
                        mode_in     = MODE_WAIT;
                     end else begin
                        step.count = 2'd1;
                        step.first = '{out_byte: cfg.delimiter_value, status: ST_OK,
                                       last_of_run: 1'b1};
                        advance    = 1'b1;
                     end
                  end
               end
               MODE_WAIT: begin
                  if (is_delim) begin
                     mode_in  = MODE_CODE;
                     swap_in  = '0;
                     block_in = cfg.block_depth;
                  end
               end
               default: begin
                  mode_in = MODE_CODE;
               end
            endcase
         end
         default: begin
         end
      endcase

      if (advance) begin
         blk_dec  = block_in - 8'd1;
         swp_dec  = swap_in - 8'd1;
         block_in = blk_dec;
         swap_in  = swp_dec;
         if (blk_dec == '0) begin
            mode_in  = MODE_CODE;
            block_in = cfg.block_depth;
         end else if (swp_dec == '0) begin
            mode_in = MODE_SWAP;
         end else begin
            mode_in = MODE_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CODE;
         swap_ff  <= '0;
         block_ff <= DEPTH_RESET;
      end else if (fire) begin
         mode_ff  <= mode_in;
         swap_ff  <= swap_in;
         block_ff <= block_in;
      end
   end

endmodule

@@ sv/cobs_rsp_buf.sv @@
// Two-entry result register: holds the results of one request and shifts
// them out one per accepted response. Depends on cobs_pkg.
module cobs_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cobs_pkg::step_type   step,
   output logic                 room,
   cobs_rsp_if.source           rsp_chan
);
   import cobs_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       pop;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   // empty after this cycle: a new request's results may be loaded
   assign room = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push) begin
         count_in = step.count;
         head_in  = step.first;
         tail_in  = step.second;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         head_in  = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.out_byte    = head_ff.out_byte;
   assign rsp_chan.status      = head_ff.status;
   assign rsp_chan.last_of_run = head_ff.last_of_run;

endmodule

@@ sv/cobs_stream_decoder.sv @@
// Top level of the byte-stuffed frame stream decoder.
// Depends on cobs_pkg, the channel interfaces, cobs_step and cobs_rsp_buf.
//
// The decoder takes one encoded byte (or a restart or resync action) per
// request and sustains one request per clock cycle while the result register
// has room. A request is first captured in an input register, then decoded
// combinationally into a two-entry result register, from which its results
// appear on the response channel. A request that yields two results (an
// oversized code at a swap position) holds the response channel for both, so
// a following request with results waits behind it; requests with no
// result never stall. Configuration writes are taken every cycle and must
// only be issued while the decoder is idle.
module cobs_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   cobs_req_if.sink   req_chan,
   cobs_rsp_if.source rsp_chan,
   cobs_csr_if.sink   csr_chan
);
   import cobs_pkg::*;

   // configuration registers
   cfg_type    cfg_ff;

   // input register
   logic       req_valid_ff;
   action_type req_action_ff;
   byte_type   req_byte_ff;

   step_type   step;
   logic       room;
   logic       fire;
   logic       req_take;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter_value <= DELIM_RESET;
         cfg_ff.block_depth     <= DEPTH_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DELIMITER: cfg_ff.delimiter_value <= csr_chan.data;
            CSR_DEPTH:     cfg_ff.block_depth     <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // Advance the held request once its results fit in the result register;
   // requests that produce nothing go through at once.
   assign fire     = req_valid_ff && ((step.count == 2'd0) || room);
   assign req_chan.ready = !req_valid_ff || fire;
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (fire) begin
         req_valid_ff <= 1'b0;
      end
      if (req_take) begin
         req_action_ff <= req_chan.action;
         req_byte_ff   <= req_chan.in_byte;
      end
   end

   cobs_step u_step (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .action  (req_action_ff),
      .in_byte (req_byte_ff),
      .cfg     (cfg_ff),
      .step    (step)
   );

   cobs_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (fire && (step.count != 2'd0)),
      .step     (step),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule
